[rtl/aac_pkg.sv]
// ----------------------------------------------------------------------------
// aac_pkg
// Shared types, codes and constants for the analog axis calibration pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aac_pkg;

    // mode selector codes carried on the input tuser
    typedef enum logic [2:0] {
        FN_STICK16   = 3'd0,
        FN_WHAMMY16  = 3'd1,
        FN_TRIGGER16 = 3'd2,
        FN_STICK8    = 3'd3,
        FN_TRIGGER8  = 3'd4,
        FN_ACCEL     = 3'd5,
        FN_WHAMMY8   = 3'd6
    } func_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_OFFSET = 3'd0,
        REG_RANGE_MINIMUM = 3'd1,
        REG_GAIN          = 3'd2,
        REG_DEAD_BAND     = 3'd3,
        REG_NARROW_ACCEL  = 3'd4,
        REG_STICK_CENTER  = 3'd5,
        REG_ACCEL_CENTER  = 3'd6
    } cfg_idx_t;

    localparam int FUNC_W     = 3;
    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OPND_W     = 18;
    localparam int PROD_W     = 34;
    localparam int WIDE_W     = 17;

    localparam int S16_FLOOR  = -32768;
    localparam int S16_CEIL   = 32767;
    localparam int U16_CEIL   = 65535;
    localparam int GAIN_SHIFT = 9;
    localparam int GAIN_ROUND = 511;

    // reset values of the registers
    localparam logic [15:0] GAIN_RST         = 16'd512;
    localparam logic [7:0]  STICK_CENTER_RST = 8'd128;
    localparam logic [9:0]  ACCEL_CENTER_RST = 10'd512;

    typedef struct packed {
        logic signed [15:0] center_offset;
        logic        [15:0] range_minimum;
        logic signed [15:0] gain;
        logic        [15:0] dead_band;
        logic               narrow_accel;
        logic        [7:0]  stick_center;
        logic        [9:0]  accel_center;
    } cfg_t;

    // word leaving the front stage
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic                     fixed;
        logic signed [OPND_W-1:0] operand;
    } prep_t;

    // word leaving the multiplier stage
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic                     fixed;
        logic signed [PROD_W-1:0] product;
    } prod_t;

    // word leaving the scale stage
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WIDE_W-1:0] wide;
    } wide_t;

    function automatic logic is_stick(input logic [FUNC_W-1:0] f);
        return f inside {FN_STICK16, FN_STICK8, FN_ACCEL};
    endfunction

    function automatic logic is_whammy(input logic [FUNC_W-1:0] f);
        return f inside {FN_WHAMMY16, FN_WHAMMY8};
    endfunction

    function automatic logic is_trigger(input logic [FUNC_W-1:0] f);
        return f inside {FN_TRIGGER16, FN_TRIGGER8};
    endfunction

endpackage

`default_nettype wire

[rtl/aac_cfg.sv]
// ----------------------------------------------------------------------------
// aac_cfg
// Configuration register file, written through a simple write port.
// ----------------------------------------------------------------------------
`default_nettype none

module aac_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [aac_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [aac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output aac_pkg::cfg_t                       cfg
);
    import aac_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_CENTER_OFFSET: cfg_next.center_offset = cfg_wdata;
                REG_RANGE_MINIMUM: cfg_next.range_minimum = cfg_wdata;
                REG_GAIN:          cfg_next.gain          = cfg_wdata;
                REG_DEAD_BAND:     cfg_next.dead_band     = cfg_wdata;
                REG_NARROW_ACCEL:  cfg_next.narrow_accel  = cfg_wdata[0];
                REG_STICK_CENTER:  cfg_next.stick_center  = cfg_wdata[7:0];
                REG_ACCEL_CENTER:  cfg_next.accel_center  = cfg_wdata[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_offset <= '0;
            cfg_reg.range_minimum <= '0;
            cfg_reg.gain          <= GAIN_RST;
            cfg_reg.dead_band     <= '0;
            cfg_reg.narrow_accel  <= 1'b0;
            cfg_reg.stick_center  <= STICK_CENTER_RST;
            cfg_reg.accel_center  <= ACCEL_CENTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/aac_prep.sv]
// ----------------------------------------------------------------------------
// aac_prep
// Front stage: deadzone tests and the signed multiplier operand.
// ----------------------------------------------------------------------------
`default_nettype none

module aac_prep (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire aac_pkg::cfg_t                cfg,
    input  wire logic                         in_valid,
    output wire logic                         in_ready,
    input  wire logic [aac_pkg::FUNC_W-1:0]   in_func,
    input  wire logic [aac_pkg::SAMPLE_W-1:0] in_sample,
    output wire logic                         out_valid,
    input  wire logic                         out_ready,
    output aac_pkg::prep_t                    out_word
);
    import aac_pkg::*;

    logic               valid_reg;
    prep_t              word_reg;
    prep_t              word_next;

    logic signed [15:0] s;
    logic signed [15:0] dz;
    logic signed [15:0] delta;
    logic signed [15:0] dz_adj;
    logic signed [16:0] delta_x;
    logic signed [16:0] dz_x;
    logic signed [16:0] ndz_x;
    logic               in_dz;
    logic signed [OPND_W-1:0] stick_op;
    logic signed [16:0] ls_diff;
    logic               ls_floor;

    // stick path: centered deadzone, then the signed operand
    always_comb begin
        s       = in_sample;
        dz      = cfg.dead_band;
        delta   = s - cfg.center_offset;
        delta_x = {delta[15], delta};
        dz_x    = {dz[15], dz};
        ndz_x   = -dz_x;
        in_dz   = (delta_x < dz_x) && (delta_x > ndz_x);
        dz_adj  = s[15] ? -dz : dz;
        stick_op = {{2{s[15]}}, s} - {{2{dz_adj[15]}}, dz_adj}
                 - {{2{cfg.range_minimum[15]}}, cfg.range_minimum};
    end

    // low-side path for whammy and trigger
    always_comb begin
        ls_diff = {1'b0, in_sample} - {1'b0, cfg.range_minimum};
        if (cfg.gain > 16'sd0) begin
            ls_floor = ls_diff < $signed({1'b0, cfg.dead_band});
        end else begin
            ls_floor = in_sample > cfg.range_minimum;
        end
    end

    // select the operand by mode
    always_comb begin
        word_next.func = in_func;
        if (is_stick(in_func)) begin
            word_next.fixed   = in_dz;
            word_next.operand = stick_op;
        end else begin
            word_next.fixed   = ls_floor;
            word_next.operand = {ls_diff[16], ls_diff};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

[rtl/aac_mul.sv]
// ----------------------------------------------------------------------------
// aac_mul
// Multiplier stage: signed operand times the signed gain.
// ----------------------------------------------------------------------------
`default_nettype none

module aac_mul (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire aac_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output wire logic           in_ready,
    input  wire aac_pkg::prep_t in_word,
    output wire logic           out_valid,
    input  wire logic           out_ready,
    output aac_pkg::prod_t      out_word
);
    import aac_pkg::*;

    logic  valid_reg;
    prod_t word_reg;
    prod_t word_next;

    // 18 x 16 signed product
    always_comb begin
        word_next.func    = in_word.func;
        word_next.fixed   = in_word.fixed;
        word_next.product = PROD_W'(in_word.operand) * PROD_W'(cfg.gain);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

[rtl/aac_scale.sv]
// ----------------------------------------------------------------------------
// aac_scale
// Scale stage: divide by 512 toward zero, add the mode offset and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module aac_scale (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output wire logic           in_ready,
    input  wire aac_pkg::prod_t in_word,
    output wire logic           out_valid,
    input  wire logic           out_ready,
    output aac_pkg::wide_t      out_word
);
    import aac_pkg::*;

    logic  valid_reg;
    wide_t word_reg;
    wide_t word_next;

    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] quot;
    logic signed [PROD_W-1:0] offset;
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] lo;
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] clamped;

    always_comb begin
        // truncating divide: bias negative products before the shift
        bias = in_word.product[PROD_W-1] ? PROD_W'(GAIN_ROUND) : '0;
        quot = (in_word.product + bias) >>> GAIN_SHIFT;

        // per-mode offset and limits
        if (is_trigger(in_word.func)) begin
            offset = '0;
            lo     = '0;
            hi     = PROD_W'(U16_CEIL);
        end else if (is_whammy(in_word.func)) begin
            offset = -PROD_W'(S16_CEIL);
            lo     = PROD_W'(S16_FLOOR);
            hi     = PROD_W'(S16_CEIL);
        end else begin
            offset = PROD_W'(S16_FLOOR);
            lo     = PROD_W'(S16_FLOOR);
            hi     = PROD_W'(S16_CEIL);
        end

        sum = quot + offset;
        if (sum > hi) begin
            clamped = hi;
        end else if (sum < lo) begin
            clamped = lo;
        end else begin
            clamped = sum;
        end

        // deadzone hits: stick gives zero, low side gives its floor
        word_next.func = in_word.func;
        if (in_word.fixed) begin
            word_next.wide = is_whammy(in_word.func) ? WIDE_W'(S16_FLOOR) : '0;
        end else begin
            word_next.wide = clamped[WIDE_W-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // trigger results are never negative
    a_trigger_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && is_trigger(word_reg.func)) |-> !word_reg.wide[WIDE_W-1])
        else $error("trigger result below zero");

    // signed modes fit in 16 bits
    a_signed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !is_trigger(word_reg.func))
            |-> (word_reg.wide[WIDE_W-1] == word_reg.wide[WIDE_W-2]))
        else $error("signed result out of 16-bit range");

    // a held word stays put while downstream stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(word_reg)))
        else $error("scale stage lost a stalled word");

endmodule

`default_nettype wire

[rtl/aac_fmt.sv]
// ----------------------------------------------------------------------------
// aac_fmt
// Output stage: narrow shifts, re-centering and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aac_fmt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire aac_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    output wire logic                        in_ready,
    input  wire aac_pkg::wide_t              in_word,
    output wire logic                        out_valid,
    input  wire logic                        out_ready,
    output wire logic [aac_pkg::VALUE_W-1:0] out_value
);
    import aac_pkg::*;

    logic               valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [15:0]        w16;
    logic [7:0]         hi8;
    logic [15:0]        accel_sh;

    always_comb begin
        w16 = in_word.wide[15:0];
        hi8 = w16[15:8];
        // floor shift of the signed result for the accel mode
        if (cfg.narrow_accel) begin
            accel_sh = {{8{w16[15]}}, hi8};
        end else begin
            accel_sh = {{6{w16[15]}}, w16[15:6]};
        end

        case (in_word.func)
            FN_STICK16, FN_WHAMMY16, FN_TRIGGER16: value_next = w16;
            FN_STICK8, FN_WHAMMY8: value_next = {8'd0, hi8 - cfg.stick_center};
            FN_TRIGGER8: value_next = {8'd0, hi8};
            FN_ACCEL:    value_next = {6'd0, cfg.accel_center} + accel_sh;
            default:     value_next = '0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            value_reg <= value_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;

endmodule

`default_nettype wire

[rtl/analog_axis_calibration.sv]
// ----------------------------------------------------------------------------
// analog_axis_calibration
// Per-sample calibration of analog controller axes in seven modes.
// ----------------------------------------------------------------------------
// Each input word carries a raw 16-bit reading in s_axis_tdata and a mode in
// s_axis_tuser; every word gives exactly one calibrated 16-bit result word.
// The block is a four-stage pipeline (deadzone/operand, 18x16 multiply,
// divide-and-clamp, narrow formatting into the output register) and takes
// one word per clock while m_axis_tready does not stall it. There is a
// single multiplier stage. Each stage holds its word under backpressure, so
// empty stages keep accepting while a result waits. Registers are written
// through cfg_we/cfg_addr/cfg_wdata, taking effect on the next clock; write
// them only while the pipeline is empty.
`default_nettype none

module analog_axis_calibration (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [aac_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [aac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  wire logic                           s_axis_tvalid,
    output wire logic                           s_axis_tready,
    input  wire logic [15:0]                    s_axis_tdata,  // [15:0] sample
    input  wire logic [2:0]                     s_axis_tuser,  // [2:0] func
    // result words
    output wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output wire logic [15:0]                    m_axis_tdata   // [15:0] value
);
    import aac_pkg::*;

    cfg_t  cfg;
    prep_t prep_word;
    prod_t prod_word;
    wide_t wide_word;
    logic  prep_valid;
    logic  prep_ready;
    logic  prod_valid;
    logic  prod_ready;
    logic  wide_valid;
    logic  wide_ready;

    aac_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aac_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_sample (s_axis_tdata),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_word  (prep_word)
    );

    aac_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_word   (prep_word),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_word  (prod_word)
    );

    aac_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_word   (prod_word),
        .out_valid (wide_valid),
        .out_ready (wide_ready),
        .out_word  (wide_word)
    );

    aac_fmt u_fmt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (wide_valid),
        .in_ready  (wide_ready),
        .in_word   (wide_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata)
    );

endmodule

`default_nettype wire

[test/tb_analog_axis_calibration.sv]
// ----------------------------------------------------------------------------
// tb_analog_axis_calibration
// Self-checking stream testbench for the analog axis calibration pipeline.
// ----------------------------------------------------------------------------
// Words go in on the s_axis side in random bursts while the m_axis side
// stalls on its own pattern. Every accepted input word is calibrated by a
// local predictor holding a private copy of the registers, and each result
// word is compared with the oldest prediction. The run starts on the reset
// settings with directed corner words, then walks through extreme, typical,
// zero-gain, reversed-gain and random register settings. Register writes
// only happen once the pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_analog_axis_calibration;
    timeunit 1ns;
    timeprecision 1ps;

    import aac_pkg::*;

    // mode code outside the defined set, still answered with a zero word
    localparam bit [2:0] FN_UNUSED = 3'd7;
    localparam int WORDS_PER_SETTING = 185;
    localparam int DRAIN_GUARD = 20000;

    typedef enum {
        SET_HIGH, SET_LOW, SET_TYPICAL, SET_ZERO_GAIN, SET_REVERSED, SET_RANDOM
    } setting_t;

    // one pending calibrated word
    typedef struct {
        bit [2:0]  func;
        bit [15:0] raw;
        bit [15:0] value;
    } cal_word_t;

    // ------------------------------------------------------------------
    // scoreboard: register copy, calibration predictor, result checking
    // ------------------------------------------------------------------
    class calibration_board;
        cfg_t      regs;
        cal_word_t calibrated_q[$];
        int        errors;
        int        inputs_seen;
        int        results_checked;

        function new();
            regs.center_offset = 16'sd0;
            regs.range_minimum = 16'd0;
            regs.gain          = 16'sd512;
            regs.dead_band     = 16'd0;
            regs.narrow_accel  = 1'b0;
            regs.stick_center  = 8'd128;
            regs.accel_center  = 10'd512;
            errors = 0;
            inputs_seen = 0;
            results_checked = 0;
        endfunction

        function int sx16(bit [15:0] v);
            return int'($signed(v));
        endfunction

        function int saturate(longint v, longint lo, longint hi);
            if (v > hi) return int'(hi);
            if (v < lo) return int'(lo);
            return int'(v);
        endfunction

        // signed stick axis with centered deadzone, -32768..32767
        function int stick_axis(bit [15:0] raw);
            int     s;
            int     dz;
            int     delta;
            longint acc;
            s     = sx16(raw);
            dz    = sx16(regs.dead_band);
            delta = sx16(16'(s - sx16(regs.center_offset)));
            if (delta < dz && delta > -dz) return 0;
            // deadzone flips with the sample sign, negated in 16 bits
            if (s < 0) dz = sx16(16'(-dz));
            acc = longint'(s) - longint'(dz) - longint'(sx16(regs.range_minimum));
            acc = acc * longint'(sx16(regs.gain));
            acc = acc / 64'sd512;
            acc = acc - 64'sd32768;
            return saturate(acc, -32768, 32767);
        endfunction

        // low-side deadzone axis: whammy -32768..32767, trigger 0..65535
        function int low_axis(bit [15:0] raw, bit trig);
            longint v;
            longint mn;
            int     g;
            int     floor_val;
            v  = longint'(raw);
            mn = longint'(regs.range_minimum);
            g  = sx16(regs.gain);
            floor_val = trig ? 0 : -32768;
            if (g > 0) begin
                if (v - mn < longint'(regs.dead_band)) return floor_val;
            end else if (v > mn) begin
                return floor_val;
            end
            v = (v - mn) * longint'(g) / 64'sd512;
            if (trig) return saturate(v, 0, 65535);
            v = v - 64'sd32767;
            return saturate(v, -32768, 32767);
        endfunction

        function bit [15:0] calibrate(bit [2:0] func, bit [15:0] raw);
            bit [15:0] r;
            int        sc;
            sc = int'(regs.stick_center);
            case (func)
                FN_STICK16:   r = 16'(stick_axis(raw));
                FN_WHAMMY16:  r = 16'(low_axis(raw, 1'b0));
                FN_TRIGGER16: r = 16'(low_axis(raw, 1'b1));
                FN_STICK8:    r = {8'd0, 8'((stick_axis(raw) >>> 8) - sc)};
                FN_TRIGGER8:  r = {8'd0, 8'(low_axis(raw, 1'b1) >> 8)};
                FN_ACCEL:     r = 16'(int'(regs.accel_center) +
                                      (stick_axis(raw) >>> (regs.narrow_accel ? 8 : 6)));
                FN_WHAMMY8:   r = {8'd0, 8'((low_axis(raw, 1'b0) >>> 8) - sc)};
                default:      r = 16'd0;
            endcase
            return r;
        endfunction

        function void note_word(bit [2:0] func, bit [15:0] raw);
            cal_word_t w;
            w.func  = func;
            w.raw   = raw;
            w.value = calibrate(func, raw);
            calibrated_q.push_back(w);
            inputs_seen++;
        endfunction

        function void check_word(logic [15:0] got);
            cal_word_t w;
            if (calibrated_q.size() == 0) begin
                if (errors < 10)
                    $display("result word %h with no input pending", got);
                errors++;
                return;
            end
            w = calibrated_q.pop_front();
            results_checked++;
            if (got !== w.value) begin
                if (errors < 10)
                    $display("mismatch func %0d sample %h: expected %h got %h",
                             w.func, w.raw, w.value, got);
                errors++;
            end
        endfunction

        function int outstanding();
            return calibrated_q.size();
        endfunction

        function void close();
            if (calibrated_q.size() != 0) begin
                $display("%0d result words never arrived", calibrated_q.size());
                errors += calibrated_q.size();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;  // [15:0] sample
    logic [2:0]            s_axis_tuser = '0;  // [2:0] func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;       // [15:0] value

    calibration_board board = new();
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int settings_run = 0;

    analog_axis_calibration dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls: always ready, mostly ready, mostly stalled, or toggling
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= stall_left[1];
        endcase
    end

    // handshake monitor on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------
    // one input word, with burst gaps in front of some
    task automatic send_word(input bit [2:0] func, input bit [15:0] raw);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= raw;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // wait for the pipeline to empty
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(posedge aclk);
        while (board.outstanding() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
    endtask

    // write every register, back to back
    task automatic write_regs(input cfg_t c);
        cfg_idx_t  idx;
        bit [15:0] val;
        idx = idx.first();
        do begin
            case (idx)
                REG_CENTER_OFFSET: val = c.center_offset;
                REG_RANGE_MINIMUM: val = c.range_minimum;
                REG_GAIN:          val = c.gain;
                REG_DEAD_BAND:     val = c.dead_band;
                REG_NARROW_ACCEL:  val = {15'd0, c.narrow_accel};
                REG_STICK_CENTER:  val = {8'd0, c.stick_center};
                default:           val = {6'd0, c.accel_center};
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= val;
            @(posedge aclk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_we <= 1'b0;
        board.regs = c;
        settings_run++;
    endtask

    function automatic cfg_t make_setting(setting_t kind);
        cfg_t c;
        c.center_offset = 16'($urandom);
        c.range_minimum = 16'($urandom);
        c.gain          = 16'($urandom);
        c.dead_band     = 16'($urandom);
        c.narrow_accel  = 1'($urandom);
        c.stick_center  = 8'($urandom);
        c.accel_center  = 10'($urandom);
        case (kind)
            SET_HIGH: begin
                c.center_offset = 16'h7FFF;
                c.range_minimum = 16'hFFFF;
                c.gain          = 16'h7FFF;
                c.dead_band     = 16'hFFFF;
                c.narrow_accel  = 1'b1;
                c.stick_center  = 8'hFF;
                c.accel_center  = 10'h3FF;
            end
            SET_LOW: begin
                c.center_offset = 16'h8000;
                c.range_minimum = 16'h0000;
                c.gain          = 16'h8000;
                c.dead_band     = 16'h0000;
                c.narrow_accel  = 1'b0;
                c.stick_center  = 8'h00;
                c.accel_center  = 10'h000;
            end
            SET_TYPICAL: begin
                c.center_offset = 16'(int'($urandom_range(0, 2000)) - 1000);
                c.range_minimum = 16'($urandom_range(0, 4000));
                c.gain          = 16'($urandom_range(256, 2048));
                c.dead_band     = 16'($urandom_range(0, 3000));
            end
            // zero gain with the deadzone that survives its own negation
            SET_ZERO_GAIN: begin
                c.gain      = 16'h0000;
                c.dead_band = 16'h8000;
            end
            SET_REVERSED: begin
                c.range_minimum = 16'($urandom_range(20000, 45000));
                c.gain          = 16'(-int'($urandom_range(256, 4096)));
                c.dead_band     = 16'($urandom_range(0, 3000));
            end
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    c.gain      = 16'(int'($urandom_range(0, 8192)) - 4096);
                    c.dead_band = 16'($urandom_range(0, 6000));
                end
            end
        endcase
        return c;
    endfunction

    // samples around the interesting points of the current setting
    function automatic bit [15:0] pick_sample();
        int co;
        int db;
        int rm;
        co = int'(board.regs.center_offset);
        db = int'(board.regs.dead_band);
        rm = int'(board.regs.range_minimum);
        case ($urandom_range(0, 9))
            5: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h0000;
                    1:       return 16'h0001;
                    2:       return 16'h7FFF;
                    3:       return 16'h8000;
                    default: return 16'hFFFF;
                endcase
            end
            6: return 16'(co + db + int'($urandom_range(0, 4)) - 2);
            7: return 16'(co - db + int'($urandom_range(0, 4)) - 2);
            8: return 16'(rm + db + int'($urandom_range(0, 4)) - 2);
            9: return 16'(rm + int'($urandom_range(0, 4)) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [2:0] pick_func();
        int r;
        r = $urandom_range(0, 63);
        if (r == 0) return FN_UNUSED;
        return 3'(r % 7);
    endfunction

    task automatic random_words(input int count);
        repeat (count) send_word(pick_func(), pick_sample());
    endtask

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        bit [15:0] corner_raw[3];
        func_t     f;
        setting_t  plan[9];
        corner_raw = '{16'h0000, 16'h7FFF, 16'h8000};
        plan = '{SET_HIGH, SET_LOW, SET_TYPICAL, SET_ZERO_GAIN, SET_REVERSED,
                 SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner samples in every mode on the reset settings
        f = f.first();
        do begin
            foreach (corner_raw[i]) send_word(f, corner_raw[i]);
            f = f.next();
        end while (f != f.first());
        send_word(FN_STICK16, 16'hFFFF);
        send_word(FN_TRIGGER16, 16'hFFFF);
        send_word(FN_UNUSED, 16'hFFFF);
        random_words(WORDS_PER_SETTING);

        // each further setting once the pipeline is empty
        foreach (plan[p]) begin
            pause_sender();
            wait_idle();
            write_regs(make_setting(plan[p]));
            random_words(WORDS_PER_SETTING);
        end

        pause_sender();
        wait_idle();
        board.close();
        $display("%0d input words sent, %0d results compared, reset plus %0d written settings",
                 board.inputs_seen, board.results_checked, settings_run);
        $display("%0d failing checks", board.errors);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("run limit reached with %0d results pending", board.outstanding());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[analog_axis_calibration.f]
rtl/aac_pkg.sv
rtl/aac_cfg.sv
rtl/aac_prep.sv
rtl/aac_mul.sv
rtl/aac_scale.sv
rtl/aac_fmt.sv
rtl/analog_axis_calibration.sv
test/tb_analog_axis_calibration.sv
